[rtl/base64_decoder_top_defines.svh]
// Assertion macros shared by the base64 decoder RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef BASE64_DECODER_TOP_DEFINES_SVH
`define BASE64_DECODER_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define B64D_ASSERT_IMM(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64d check failed");

// Check that cons holds in the cycle after ante.
`define B64D_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64d check failed");

`endif

[rtl/b64d_pkg.sv]
// Types, constants and the character classifier of the base64 decoder.
// Depends on nothing; used by the output interface, front end, queue, back end and top level.
`timescale 1ns / 1ps

package b64d_pkg;

    localparam int COUNT_BITS_DEFAULT = 16;
    // Queue depth between front and back, a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int TOTAL_W = 16;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 16'hFFFF;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PAD     = 8'h3D;

    localparam logic [7:0] LOWER_BASE = 8'd26;
    localparam logic [7:0] DIGIT_BASE = 8'd52;
    localparam logic [5:0] PLUS_VALUE  = 6'd62;
    localparam logic [5:0] SLASH_VALUE = 6'd63;

    typedef enum logic [1:0] {
        SYM_DATA,
        SYM_PAD,
        SYM_BAD
    } t_sym_kind;

    typedef struct packed {
        t_sym_kind  kind;
        logic [5:0] value;
    } t_sym;

    // Work for the back end: up to three bytes, then an optional summary.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      nbytes;
        logic            done;
        logic            status;
    } t_job;

    typedef struct packed {
        logic push;
        t_job job;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef struct packed {
        logic [7:0]         data_byte;
        logic               is_byte;
        logic               is_done;
        logic               status;
        logic [TOTAL_W-1:0] byte_total;
    } t_result;

    // Map one character to its sextet, or mark it as pad or invalid.
    function automatic t_sym classify(input logic [7:0] c);
        t_sym       s;
        logic [7:0] d;
        s.kind  = SYM_DATA;
        s.value = '0;
        d       = '0;
        if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
            d = c - CH_UPPER_A;
        end else if (c inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
            d = c - CH_LOWER_A + LOWER_BASE;
        end else if (c inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
            d = c - CH_DIGIT_0 + DIGIT_BASE;
        end else if (c == CH_PLUS) begin
            d = {2'b00, PLUS_VALUE};
        end else if (c == CH_SLASH) begin
            d = {2'b00, SLASH_VALUE};
        end else if (c == CH_PAD) begin
            s.kind = SYM_PAD;
        end else begin
            s.kind = SYM_BAD;
        end
        s.value = d[5:0];
        return s;
    endfunction

endpackage

[rtl/b64d_in_if.sv]
// Input channel of the base64 decoder: one character and an end flag.
// Depends on nothing.
`timescale 1ns / 1ps

interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       end_of_message;

    modport source (output valid, output symbol, output end_of_message, input ready);
    modport sink   (input valid, input symbol, input end_of_message, output ready);
endinterface

[rtl/b64d_out_if.sv]
// Output channel of the base64 decoder: decoded bytes and the summary.
// Depends on b64d_pkg for the byte total width.
`timescale 1ns / 1ps

interface b64d_out_if;
    logic                         valid;
    logic                         ready;
    logic [7:0]                   data_byte;
    logic                         is_byte;
    logic                         is_done;
    logic                         status;
    logic [b64d_pkg::TOTAL_W-1:0] byte_total;

    modport source (output valid, output data_byte, output is_byte, output is_done,
                    output status, output byte_total, input ready);
    modport sink   (input valid, input data_byte, input is_byte, input is_done,
                    input status, input byte_total, output ready);
endinterface

[rtl/b64d_front.sv]
// Front end: accepts characters, tracks the group and error state, queues jobs.
// Depends on b64d_pkg and b64d_in_if.
`timescale 1ns / 1ps

module b64d_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    b64d_in_if.sink                 i_in,
    input  b64d_pkg::t_queue_status i_qstat,
    output b64d_pkg::t_push         o_push
);

    logic [1:0]  r_pos, n_pos;
    logic [23:0] r_holder, n_holder;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_err, n_err;

    b64d_pkg::t_sym sym;
    b64d_pkg::t_job job;
    logic           accept;
    logic [23:0]    holder_s;
    logic [2:0]     cnt_s;
    logic [1:0]     pos_s;

    // Take a character whenever the queue has room.
    assign i_in.ready = !i_qstat.full;
    assign accept     = i_in.valid && i_in.ready;
    assign sym        = b64d_pkg::classify(i_in.symbol);

    // Advance the group and build the job for this character.
    always_comb begin
        n_pos    = r_pos;
        n_holder = r_holder;
        n_cnt    = r_cnt;
        n_err    = r_err;
        job      = '0;
        holder_s = {r_holder[17:0], (sym.kind == b64d_pkg::SYM_PAD) ? 6'd0 : sym.value};
        cnt_s    = r_cnt + ((sym.kind == b64d_pkg::SYM_DATA) ? 3'd1 : 3'd0);
        pos_s    = r_pos + 2'd1;
        if (accept) begin
            if (!r_err) begin
                if (sym.kind == b64d_pkg::SYM_BAD) begin
                    n_err = 1'b1;
                end else begin
                    n_holder = holder_s;
                    n_cnt    = cnt_s;
                    n_pos    = pos_s;
                    if (pos_s == 2'd0) begin
                        // Group closed: an all-pad group is an error.
                        if (cnt_s == 3'd0) begin
                            n_err = 1'b1;
                        end else begin
                            job.nbytes   = 2'(cnt_s - 3'd1);
                            job.bytes[0] = holder_s[23:16];
                            job.bytes[1] = holder_s[15:8];
                            job.bytes[2] = holder_s[7:0];
                        end
                        n_holder = '0;
                        n_cnt    = '0;
                    end
                end
            end
            // Close the message: summary after any bytes, then clear.
            if (i_in.end_of_message) begin
                job.done   = 1'b1;
                job.status = n_err;
                n_pos      = '0;
                n_holder   = '0;
                n_cnt      = '0;
                n_err      = 1'b0;
            end
        end
    end

    assign o_push.push = accept && ((job.nbytes != 2'd0) || job.done);
    assign o_push.job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_holder <= '0;
            r_cnt    <= '0;
            r_err    <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_holder <= n_holder;
            r_cnt    <= n_cnt;
            r_err    <= n_err;
        end
    end

endmodule

[rtl/b64d_queue.sv]
// Short job queue between the front end and the back end.
// Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  b64d_pkg::t_push         i_push,
    input  logic                    i_pop,
    output b64d_pkg::t_job          o_head,
    output b64d_pkg::t_queue_status o_stat
);

    localparam int DEPTH  = b64d_pkg::QUEUE_DEPTH;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    b64d_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [FILL_W-1:0] r_fill, n_fill;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_fill == FILL_W'(DEPTH));
    assign o_stat.empty = (r_fill == '0);

    // Advance pointers and fill level.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (i_push.push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push.push && !i_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (!i_push.push && i_pop) begin
            n_fill = r_fill - 1'b1;
        end
    end

    // Store the pushed job.
    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

endmodule

[rtl/b64d_back.sv]
// Back end: walks each queued job into the output register, one result per cycle while the output is not stalled.
// Depends on b64d_pkg, b64d_out_if and the assertion macro header.
`timescale 1ns / 1ps
`include "base64_decoder_top_defines.svh"

module b64d_back #(
    parameter int COUNT_BITS = b64d_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  b64d_pkg::t_job          i_head,
    input  b64d_pkg::t_queue_status i_qstat,
    output logic                    o_pop,
    b64d_out_if.source              o_out
);

    localparam int WIDE_W = (COUNT_BITS > b64d_pkg::TOTAL_W) ? COUNT_BITS : b64d_pkg::TOTAL_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [1:0]            r_idx, n_idx;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_valid, n_valid;
    b64d_pkg::t_result     r_res, n_res;

    logic                           can_load;
    logic                           issue;
    logic                           sel_byte;
    logic                           last;
    logic [7:0]                     pick;
    logic [COUNT_BITS-1:0]          count_inc;
    logic [COUNT_BITS-1:0]          tot_src;
    logic [WIDE_W-1:0]              wide;
    logic [b64d_pkg::TOTAL_W-1:0]   total;
    b64d_pkg::t_result              res;

    assign can_load = !r_valid || o_out.ready;
    assign issue    = can_load && !i_qstat.empty;
    assign sel_byte = (r_idx < i_head.nbytes);

    // Pick the byte at the current index.
    always_comb begin
        case (r_idx)
            2'd0:    pick = i_head.bytes[0];
            2'd1:    pick = i_head.bytes[1];
            default: pick = i_head.bytes[2];
        endcase
    end

    // Saturating byte count and the reported total.
    always_comb begin
        count_inc = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;
        tot_src   = sel_byte ? count_inc : r_count;
        wide      = WIDE_W'(tot_src);
        total     = (wide > WIDE_W'(b64d_pkg::TOTAL_MAX)) ? b64d_pkg::TOTAL_MAX
                                                           : wide[b64d_pkg::TOTAL_W-1:0];
    end

    // Form the result and decide whether it ends the job.
    always_comb begin
        last           = sel_byte ? (((r_idx + 2'd1) == i_head.nbytes) && !i_head.done) : 1'b1;
        res.data_byte  = sel_byte ? pick : 8'd0;
        res.is_byte    = sel_byte;
        res.is_done    = !sel_byte;
        res.status     = sel_byte ? 1'b0 : i_head.status;
        res.byte_total = total;
    end

    // Advance the index and counter, load the output register.
    always_comb begin
        n_idx   = r_idx;
        n_count = r_count;
        n_valid = r_valid;
        n_res   = r_res;
        if (can_load) begin
            n_valid = issue;
        end
        if (issue) begin
            n_res   = res;
            n_idx   = last ? 2'd0 : r_idx + 2'd1;
            n_count = sel_byte ? count_inc : '0;
        end
    end

    assign o_pop = issue && last;

    assign o_out.valid      = r_valid;
    assign o_out.data_byte  = r_res.data_byte;
    assign o_out.is_byte    = r_res.is_byte;
    assign o_out.is_done    = r_res.is_done;
    assign o_out.status     = r_res.status;
    assign o_out.byte_total = r_res.byte_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // Hold payload without reset.
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    `B64D_ASSERT_IMM(a_pop_nonempty, i_clk, i_rst_n, o_pop, !i_qstat.empty)
    `B64D_ASSERT_IMM(a_kind_exclusive, i_clk, i_rst_n, r_valid, r_res.is_byte != r_res.is_done)
    `B64D_ASSERT_NXT(a_count_clears, i_clk, i_rst_n, issue && !sel_byte, r_count == '0)
    `B64D_ASSERT_IMM(a_idx_in_range, i_clk, i_rst_n, !i_qstat.empty, r_idx <= i_head.nbytes)

endmodule

[rtl/base64_decoder_top.sv]
// Base64 decoder top level: front end, job queue and back end.
// Depends on b64d_pkg, b64d_in_if, b64d_out_if, b64d_front, b64d_queue, b64d_back.
`timescale 1ns / 1ps

// Streaming base64 decoder. One character is accepted per cycle while the
// four-entry job queue has room; a character is classified and folded into
// its group in that cycle. A group that closes emits up to three bytes, and
// the last character of a message adds a summary result, so one character
// can cause up to four results. The back end delivers one result per cycle
// from the queue into an output register while the output is not stalled;
// this sets the output rate. A full group of four characters yields at most
// three bytes, so an unstalled stream runs at one character per cycle, and
// the queue absorbs the burst of a closing group plus summary. The decoded byte
// count saturates at 2^COUNT_BITS - 1 internally and is reported capped at
// 0xFFFF. Results with a set status mean earlier bytes of that message must
// be discarded.
module base64_decoder_top #(
    parameter int COUNT_BITS = b64d_pkg::COUNT_BITS_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    b64d_in_if.sink    i_in,
    b64d_out_if.source o_out
);

    b64d_pkg::t_push         push;
    b64d_pkg::t_job          head;
    b64d_pkg::t_queue_status qstat;
    logic                    pop;

    b64d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_qstat (qstat),
        .o_push  (push)
    );

    b64d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    b64d_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

[test/b64d_checker.sv]
// Scoreboard for the base64 decoder: watches both channels, predicts results, compares them.
// Depends on b64d_pkg, b64d_in_if and b64d_out_if.
`timescale 1ns / 1ps

module b64d_checker #(
    parameter int COUNT_BITS = b64d_pkg::COUNT_BITS_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    b64d_in_if   i_in_mon,
    b64d_out_if  i_out_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_live_items,
    output int   o_msg_count,
    output int   o_byte_count
);
    import b64d_pkg::*;

    localparam logic [63:0] COUNT_CAP = (64'd1 << COUNT_BITS) - 64'd1;
    localparam int MAX_REPORTS = 200;

    // Decoder state as predicted from the accepted characters
    logic [1:0]  grp_pos;
    logic [23:0] grp_bits;
    logic [2:0]  grp_data_cnt;
    logic        msg_bad;
    logic [63:0] msg_bytes;

    t_result want_results[$];
    t_result want_res;
    t_result seen_res;
    int      fail_total;
    int      live_total;
    int      msg_total;
    int      byte_total_seen;

    function automatic t_sym_kind char_kind(input logic [7:0] ch, output logic [5:0] val);
        logic [7:0] d;
        d   = '0;
        val = '0;
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
            d = ch - CH_UPPER_A;
        end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
            d = ch - CH_LOWER_A + 8'd26;
        end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
            d = ch - CH_DIGIT_0 + 8'd52;
        end else if (ch == CH_PLUS) begin
            d = 8'd62;
        end else if (ch == CH_SLASH) begin
            d = 8'd63;
        end else if (ch == CH_PAD) begin
            return SYM_PAD;
        end else begin
            return SYM_BAD;
        end
        val = d[5:0];
        return SYM_DATA;
    endfunction

    function automatic void clear_state();
        grp_pos      = '0;
        grp_bits     = '0;
        grp_data_cnt = '0;
        msg_bad      = 1'b0;
        msg_bytes    = '0;
    endfunction

    // Queue one expected result; the reported total is capped at 16 bits
    function automatic void add_result(input logic [7:0] data, input logic isb,
                                       input logic done, input logic st);
        t_result r;
        r.data_byte  = data;
        r.is_byte    = isb;
        r.is_done    = done;
        r.status     = st;
        r.byte_total = (msg_bytes > TOTAL_MAX) ? TOTAL_MAX : msg_bytes[TOTAL_W-1:0];
        want_results.push_back(r);
    endfunction

    // Fold one character into the current group and emit what it causes
    function automatic void decode_char(input logic [7:0] ch, input logic last);
        t_sym_kind  kind;
        logic [5:0] val;
        if (!msg_bad) begin
            live_total++;
            kind = char_kind(ch, val);
            if (kind == SYM_BAD) begin
                msg_bad = 1'b1;
            end else begin
                grp_bits = {grp_bits[17:0], (kind == SYM_PAD) ? 6'd0 : val};
                if (kind == SYM_DATA) grp_data_cnt = grp_data_cnt + 3'd1;
                grp_pos = grp_pos + 2'd1;
                if (grp_pos == 2'd0) begin
                    // a group of pads only is an error, otherwise emit count-1 bytes
                    if (grp_data_cnt == 3'd0) begin
                        msg_bad = 1'b1;
                    end else begin
                        for (int i = 0; i + 1 < grp_data_cnt && i < 3; i++) begin
                            if (msg_bytes < COUNT_CAP) msg_bytes++;
                            add_result(grp_bits[23 - 8 * i -: 8], 1'b1, 1'b0, 1'b0);
                        end
                    end
                    grp_bits     = '0;
                    grp_data_cnt = '0;
                end
            end
        end
        if (last) begin
            add_result(8'd0, 1'b0, 1'b1, msg_bad);
            msg_total++;
            clear_state();
        end
    endfunction

    function automatic void check_field(input string fname, input logic [15:0] want,
                                        input logic [15:0] seen);
        if (seen !== want) begin
            fail_total++;
            if (fail_total <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, fname, want, seen);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
            want_results.delete();
            fail_total      = 0;
            live_total      = 0;
            msg_total       = 0;
            byte_total_seen = 0;
        end else begin
            // Check the result first: it cannot stem from a character taken this edge
            if (i_out_mon.valid && i_out_mon.ready) begin
                seen_res.data_byte  = i_out_mon.data_byte;
                seen_res.is_byte    = i_out_mon.is_byte;
                seen_res.is_done    = i_out_mon.is_done;
                seen_res.status     = i_out_mon.status;
                seen_res.byte_total = i_out_mon.byte_total;
                if (want_results.size() == 0) begin
                    fail_total++;
                    if (fail_total <= MAX_REPORTS) begin
                        $display("%0t: unexpected result, expected none, actual %p",
                                 $time, seen_res);
                    end
                end else begin
                    want_res = want_results.pop_front();
                    check_field("data_byte", 16'(want_res.data_byte), 16'(seen_res.data_byte));
                    check_field("is_byte", 16'(want_res.is_byte), 16'(seen_res.is_byte));
                    check_field("is_done", 16'(want_res.is_done), 16'(seen_res.is_done));
                    check_field("status", 16'(want_res.status), 16'(seen_res.status));
                    check_field("byte_total", want_res.byte_total, seen_res.byte_total);
                    if (seen_res.is_byte) byte_total_seen++;
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                decode_char(i_in_mon.symbol, i_in_mon.end_of_message);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= want_results.size();
        o_live_items <= live_total;
        o_msg_count  <= msg_total;
        o_byte_count <= byte_total_seen;
    end

endmodule

[test/tb_top.sv]
// Testbench top for base64_decoder_top: clock, reset, character stimulus and verdict.
// Depends on b64d_pkg, the channel interfaces, the decoder RTL and b64d_checker.
`timescale 1ns / 1ps

module tb_top;
    import b64d_pkg::*;

    localparam int COUNT_BITS   = COUNT_BITS_DEFAULT;
    localparam int RANDOM_ITEMS = 220;
    localparam int DRAIN_CYCLES = 16;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   live_items;
    int   msg_count;
    int   byte_count;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   random_base;

    b64d_in_if  in_ch ();
    b64d_out_if out_ch ();

    base64_decoder_top #(.COUNT_BITS(COUNT_BITS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    b64d_checker #(.COUNT_BITS(COUNT_BITS)) u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_live_items (live_items),
        .o_msg_count  (msg_count),
        .o_byte_count (byte_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Stall the result channel at the rate of the current phase
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [7:0] pick_alpha();
        int k;
        k = $urandom_range(63);
        if (k < 26) return CH_UPPER_A + 8'(k);
        if (k < 52) return CH_LOWER_A + 8'(k - 26);
        if (k < 62) return CH_DIGIT_0 + 8'(k - 52);
        if (k == 62) return CH_PLUS;
        return CH_SLASH;
    endfunction

    // Offer one character, with random idle cycles ahead of it, and hold until taken
    task automatic send_char(input logic [7:0] ch, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.symbol         <= ch;
        in_ch.end_of_message <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_text(input string s, input logic flag_last);
        for (int i = 0; i < s.len(); i++) send_char(s[i], flag_last && i == s.len() - 1);
    endtask

    task automatic send_msg(input logic [7:0] chars[$]);
        for (int i = 0; i < chars.size(); i++) send_char(chars[i], i == chars.size() - 1);
    endtask

    // Wait until every predicted result has arrived, then let the pipeline settle
    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly well-formed messages with random content, some pad, error and noise cases
    task automatic random_message();
        logic [7:0] chars[$];
        int         groups;
        int         pads;
        int         kind;
        int         pos;
        kind   = $urandom_range(99);
        groups = $urandom_range(1, 5);
        for (int g = 0; g < groups * 4; g++) chars.push_back(pick_alpha());
        if (kind < 55) begin
            // standard tail padding, sometimes a dangling partial group
            pads = $urandom_range(0, 2);
            for (int p = 0; p < pads; p++) chars[chars.size() - 1 - p] = CH_PAD;
            if ($urandom_range(4) == 0) begin
                repeat ($urandom_range(1, 3)) chars.push_back(pick_alpha());
            end
        end else if (kind < 70) begin
            // pads scattered anywhere, also ahead of data
            repeat ($urandom_range(1, 4)) chars[$urandom_range(chars.size() - 1)] = CH_PAD;
        end else if (kind < 80) begin
            pos = 4 * $urandom_range(groups - 1);
            for (int p = 0; p < 4; p++) chars[pos + p] = CH_PAD;
        end else if (kind < 90) begin
            chars[$urandom_range(chars.size() - 1)] = 8'($urandom_range(255));
        end else begin
            chars.delete();
            repeat ($urandom_range(1, 8)) chars.push_back(8'($urandom_range(255)));
        end
        send_msg(chars);
    endtask

    initial begin
        in_ch.valid          <= 1'b0;
        in_ch.symbol         <= 8'd0;
        in_ch.end_of_message <= 1'b0;
        i_rst_n              <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Alphabet extremes, then pads ahead of data and a dropped partial group
        send_text("Az9+aZ0/", 1'b1);
        send_text("=A====ABQ", 1'b1);
        // Group closed by the final character: three bytes plus summary
        send_text("QUJD", 1'b1);
        send_text("====", 1'b1);
        // Invalid characters at both ends of the byte range
        send_char(8'h00, 1'b0);
        send_text("TW", 1'b1);
        send_text("TW", 1'b0);
        send_char(8'hFF, 1'b1);
        in_ch.valid <= 1'b0;
        drain();

        random_base = live_items;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 53;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 53;
                end
                default: begin
                    send_idle_pct  = 36;
                    recv_stall_pct = 36;
                end
            endcase
            while (live_items < random_base + RANDOM_ITEMS * (ph + 1) / 4) begin
                random_message();
                // now and then hold off until the decoder has emptied out
                if ($urandom_range(15) == 0) begin
                    in_ch.valid <= 1'b0;
                    drain();
                end
            end
            in_ch.valid <= 1'b0;
            drain();
        end

        $display("Run covered %0d messages and %0d decoded bytes, under four idle and stall mixes,",
                 msg_count, byte_count);
        $display("including pad placement, all-pad groups and invalid-character cases.");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
